### hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] task_id;
    logic [7:0] prio;
  } in_word_t;

  typedef struct packed {
    logic [7:0] popped_task;
    logic       popped_valid;
    logic [7:0] head_task;
    logic [7:0] head_prio;
    logic       is_empty;
    logic [5:0] entry_count;
    logic       overflow;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
module spq_cell #(
  parameter int ID_BITS   = 8,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  spq_pkg::spq_ctrl_t   ctrl,
  input  logic                 occupied,
  input  logic [ID_BITS-1:0]   new_task,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 prev_stays,
  input  logic [ID_BITS-1:0]   prev_task,
  input  logic [PRIO_BITS-1:0] prev_prio,
  input  logic [ID_BITS-1:0]   next_task,
  input  logic [PRIO_BITS-1:0] next_prio,
  output logic                 stays,
  output logic [ID_BITS-1:0]   task_q,
  output logic [PRIO_BITS-1:0] prio_q,
  output logic [ID_BITS-1:0]   task_nxt,
  output logic [PRIO_BITS-1:0] prio_nxt
);
  import spq_pkg::*;

  logic [ID_BITS-1:0]   task_r;
  logic [PRIO_BITS-1:0] prio_r;

  // an entry with equal or lower number keeps its place ahead of the new one
  assign stays = occupied && (prio_r <= new_prio);

  always_comb begin
    task_nxt = task_r;
    prio_nxt = prio_r;
    if (ctrl.push) begin
      if (!stays) begin
        if (prev_stays) begin
          task_nxt = new_task;
          prio_nxt = new_prio;
        end else begin
          task_nxt = prev_task;
          prio_nxt = prev_prio;
        end
      end
    end else if (ctrl.pop) begin
      task_nxt = next_task;
      prio_nxt = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    prio_r <= prio_nxt;
  end

  assign task_q = task_r;
  assign prio_q = prio_r;

endmodule

### hw/rtl/stable_sorted_priority_queue.sv
// stable sorted priority queue of task handles
//
// input channel (in_valid / in_stall / in_word): one word is one command,
// op push inserts task_id with prio, op pop removes the head entry. entries
// are kept sorted by ascending prio in a row of cells; equal priorities leave
// in arrival order. a push into a full queue is dropped and flagged overflow.
//
// result channel (out_valid / out_stall / out_word): exactly one word per
// command, shown in the cycle after the command is accepted. it carries the
// popped handle, the head after the command, the empty flag and the count.
//
// throughput is one command per cycle while the output is not stalled: every
// cell compares and shifts in the same cycle. the result sits in an output
// register; while the receiver stalls and that register is full, in_stall
// is raised and no further command is taken.
//
// reset clears the entry count and the output valid; cell contents are left
// as they are and only read once written.
module stable_sorted_priority_queue #(
  parameter int DEPTH     = 32,
  parameter int ID_BITS   = 8,
  parameter int PRIO_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_word_t out_word
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // control
  logic               accept;
  logic               is_push;
  logic               full;
  logic               empty;
  spq_ctrl_t          ctrl;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // new entry, fitted to the stored widths
  logic [39:0]          id_ext;
  logic [39:0]          pr_ext;
  logic [ID_BITS-1:0]   new_task;
  logic [PRIO_BITS-1:0] new_prio;

  // cell row wiring
  logic                 cell_occ   [DEPTH];
  logic                 cell_stays [DEPTH];
  logic                 prev_stays [DEPTH];
  logic [ID_BITS-1:0]   cell_task  [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
  logic [ID_BITS-1:0]   prev_task  [DEPTH];
  logic [PRIO_BITS-1:0] prev_prio  [DEPTH];
  logic [ID_BITS-1:0]   next_task  [DEPTH];
  logic [PRIO_BITS-1:0] next_prio  [DEPTH];
  logic [ID_BITS-1:0]   task_nxt   [DEPTH];
  logic [PRIO_BITS-1:0] prio_nxt   [DEPTH];

  // result assembly
  logic [39:0]  head_task_ext;
  logic [39:0]  head_prio_ext;
  logic [39:0]  pop_task_ext;
  logic [31:0]  count_ext;
  out_word_t    res;
  logic         out_valid_r;
  logic         out_valid_nxt;
  out_word_t    out_word_r;

  // output register full and not draining holds off the input
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign is_push = (in_word.op == OP_PUSH);

  assign ctrl.push = accept && is_push && !full;
  assign ctrl.pop  = accept && !is_push && !empty;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign id_ext   = 40'(in_word.task_id);
  assign pr_ext   = 40'(in_word.prio);
  assign new_task = id_ext[ID_BITS-1:0];
  assign new_prio = pr_ext[PRIO_BITS-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign cell_occ[gi] = (CNT_W'(gi) < count_r);

      // head cell sees an always-staying neighbor in front of it
      if (gi == 0) begin : g_head
        assign prev_stays[gi] = 1'b1;
        assign prev_task[gi]  = '0;
        assign prev_prio[gi]  = '0;
      end else begin : g_body
        assign prev_stays[gi] = cell_stays[gi-1];
        assign prev_task[gi]  = cell_task[gi-1];
        assign prev_prio[gi]  = cell_prio[gi-1];
      end

      // tail cell pulls in nothing on a pop
      if (gi == DEPTH - 1) begin : g_tail
        assign next_task[gi] = '0;
        assign next_prio[gi] = '0;
      end else begin : g_inner
        assign next_task[gi] = cell_task[gi+1];
        assign next_prio[gi] = cell_prio[gi+1];
      end

      spq_cell #(
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (cell_occ[gi]),
        .new_task   (new_task),
        .new_prio   (new_prio),
        .prev_stays (prev_stays[gi]),
        .prev_task  (prev_task[gi]),
        .prev_prio  (prev_prio[gi]),
        .next_task  (next_task[gi]),
        .next_prio  (next_prio[gi]),
        .stays      (cell_stays[gi]),
        .task_q     (cell_task[gi]),
        .prio_q     (cell_prio[gi]),
        .task_nxt   (task_nxt[gi]),
        .prio_nxt   (prio_nxt[gi])
      );
    end
  endgenerate

  // head after the command is what the front cell is about to hold
  assign head_task_ext = 40'(task_nxt[0]);
  assign head_prio_ext = 40'(prio_nxt[0]);
  assign pop_task_ext  = 40'(cell_task[0]);
  assign count_ext     = 32'(count_nxt);

  always_comb begin
    res              = '0;
    res.popped_valid = ctrl.pop;
    res.popped_task  = ctrl.pop ? pop_task_ext[7:0] : 8'd0;
    res.is_empty     = (count_nxt == '0);
    res.head_task    = res.is_empty ? 8'd0 : head_task_ext[7:0];
    res.head_prio    = res.is_empty ? 8'd0 : head_prio_ext[7:0];
    res.entry_count  = count_ext[5:0];
    res.overflow     = is_push && full;
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
